### design/hptm_pkg.sv
package hptm_pkg;

   // input converted to q16, wide enough for 8 or more input fraction bits
   localparam int X_W      = 32;
   localparam int NUM_CH   = 3;
   localparam int IN_FRAC_BITS_DEF = 16;

   // transform_mode codes
   localparam logic [2:0] MODE_LINEAR = 3'd0;
   localparam logic [2:0] MODE_SRGB   = 3'd1;
   localparam logic [2:0] MODE_REC709 = 3'd2;
   localparam logic [2:0] MODE_ACES_A = 3'd3;
   localparam logic [2:0] MODE_ACES_B = 3'd4;
   localparam logic [2:0] MODE_ACES_C = 3'd5;

   // aces fit matrices, q16
   localparam logic [15:0] IN_MAT [9] = '{
      16'd39137, 16'd23238, 16'd3161,
      16'd4981,  16'd59529, 16'd1026,
      16'd1861,  16'd8771,  16'd54904
   };
   localparam logic signed [17:0] OUT_MAT [9] = '{
      18'sd105169, -18'sd34805, -18'sd4828,
      -18'sd6690,  18'sd72622,  -18'sd396,
      -18'sd214,   -18'sd4768,  18'sd70518
   };

   localparam int BINOM [7][7] = '{
      '{1, 0, 0, 0, 0, 0, 0},
      '{1, 1, 0, 0, 0, 0, 0},
      '{1, 2, 1, 0, 0, 0, 0},
      '{1, 3, 3, 1, 0, 0, 0},
      '{1, 4, 6, 4, 1, 0, 0},
      '{1, 5, 10, 10, 5, 1, 0},
      '{1, 6, 15, 20, 15, 6, 1}
   };

   // pipeline stage map
   localparam int DIV_STEPS  = 18;
   localparam int ROOT_STEPS = 15;
   localparam int S_IN    = 0;
   localparam int S_ROW   = 1;
   localparam int S_P     = 2;
   localparam int S_AL    = 3;
   localparam int S_BQ    = 4;
   localparam int S_B     = 5;
   localparam int S_DIV0  = 6;
   localparam int S_F     = S_DIV0 + DIV_STEPS;
   localparam int S_OM    = S_F + 1;
   localparam int S_OS    = S_OM + 1;
   localparam int S_ROOT0 = S_OS + 1;
   localparam int S_PP    = S_ROOT0 + ROOT_STEPS;
   localparam int S_YK    = S_PP + 1;
   localparam int S_Y     = S_YK + 1;
   localparam int S_OUT   = S_Y + 1;
   localparam int NUM_STAGES = S_OUT + 1;

   typedef struct packed {
      logic [2:0]             mode;
      logic [2:0][X_W-1:0]    x;
      logic [8:0][47:0]       im_prod;
      logic [2:0][24:0]       v;
      logic [2:0][49:0]       p1;
      logic [2:0][40:0]       p2;
      logic [2:0][46:0]       a;
      logic [2:0][24:0]       lin;
      logic [2:0][49:0]       bq;
      logic [2:0][46:0]       b;
      logic [2:0][63:0]       num;
      logic [2:0]             neg;
      logic [2:0][17:0]       quo;
      logic [2:0][18:0]       f;
      logic [8:0][36:0]       om_prod;
      logic [2:0]             ge1;
      logic [2:0][15:0]       xe;
      logic [2:0][6:0][63:0]  pw4;
      logic [2:0][6:0][63:0]  pw6;
      logic [2:0][6:0][63:0]  pw5;
      logic [2:0][26:0]       pp;
      logic [2:0][51:0]       yk;
      logic [2:0][35:0]       sm;
      logic [2:0][31:0]       y;
      logic [2:0][7:0]        px;
   } pipe_type;

   // one bit of a floor k-th root; pw holds y^1..y^k of the partial root
   function automatic logic [6:0][63:0] root_step(input logic [6:0][63:0] pw, input int k,
                                                  input int b, input logic [15:0] x);
      logic [6:0][63:0] base;
      logic [6:0][63:0] tp;
      logic [63:0]      target;
      base    = pw;
      base[0] = 64'd1;
      tp      = '0;
      target  = {4'b0, x, 44'b0};
      for (int j = 1; j <= 6; j++) begin
         if (j <= k) begin
            for (int i = 0; i <= j; i++) begin
               tp[j] = tp[j] + ((64'(BINOM[j][i]) * base[j-i]) << (i * b));
            end
         end
      end
      if (tp[k] <= target) begin
         return tp;
      end
      return pw;
   endfunction

endpackage

### design/hdr_pixel_tone_map_to_8bit.sv
// hdr pixel tone mapper, linear 8.16 rgb in, display-encoded 8-bit rgb out
//
// req_* carries one pixel per word, rsp_* one encoded pixel per word; a word
// moves on a clock edge with tvalid and tready both high. csr_we/csr_wdata
// write transform_mode (0 linear, 1 srgb, 2 rec709, 3..5 aces fit then srgb,
// 6..7 black); write it only while no pixel is in flight.
//
// throughput: one pixel per clock while rsp_tready holds no result back. the
// pipe holds the 18-step restoring divider of the aces curve and the 15-step
// bitwise root unit of the display curves, plus the matrix and multiply stages.
// every pixel takes the same path whatever the mode, so order is kept.
//
// each stage has its own valid bit and advances when it is empty or the next
// stage advances, so bubbles close up and input keeps being taken while a
// result waits on rsp_tready, until the pipe is full. nothing is dropped or
// repeated under stall.
//
// reset (synchronous, active high) empties the pipe and sets mode to srgb.
module hdr_pixel_tone_map_to_8bit
   import hptm_pkg::*;
#(
   parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // red_in, green_in, blue_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out, green_out, blue_out
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata    // transform_mode
);

   localparam int SH_R = (IN_FRAC_BITS > 16) ? IN_FRAC_BITS - 16 : 0;
   localparam int SH_L = (IN_FRAC_BITS < 16) ? 16 - IN_FRAC_BITS : 0;

   logic [2:0] mode_ff;
   pipe_type   pipe_ff  [NUM_STAGES];
   pipe_type   pipe_in  [NUM_STAGES];
   pipe_type   pipe_src [NUM_STAGES];
   logic       valid_ff [NUM_STAGES];
   logic       valid_in [NUM_STAGES];
   logic       stage_en [NUM_STAGES + 1];

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SRGB;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   assign stage_en[NUM_STAGES] = rsp_tready;
   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {pipe_ff[NUM_STAGES-1].px[2], pipe_ff[NUM_STAGES-1].px[1],
                        pipe_ff[NUM_STAGES-1].px[0]};

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      if (i == 0) begin : g_head
         assign pipe_src[i] = '0;
         assign valid_in[i] = req_tvalid;
      end else begin : g_body
         assign pipe_src[i] = pipe_ff[i-1];
         assign valid_in[i] = valid_ff[i-1];
      end

      // stage moves when empty or when the next one moves
      assign stage_en[i] = !valid_ff[i] || stage_en[i+1];

      always_comb begin
         pipe_type         p;
         logic [49:0]      rs;
         logic [33:0]      s16;
         logic [46:0]      mag;
         logic [64:0]      trial;
         logic signed [38:0] os;
         logic [22:0]      mv;
         logic [X_W-1:0]   val;
         logic [39:0]      lb;
         logic [39:0]      yb;
         logic             aces;
         logic             rec;
         logic             small_in;
         p = pipe_src[i];
         aces = (p.mode == MODE_ACES_A) || (p.mode == MODE_ACES_B) ||
                (p.mode == MODE_ACES_C);
         rec = (p.mode == MODE_REC709);
         if (i == S_IN) begin
            p.mode = mode_ff;
            for (int c = 0; c < NUM_CH; c++) begin
               p.x[c] = (X_W'(req_tdata[24*c +: 24]) >> SH_R) << SH_L;
            end
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < NUM_CH; c++) begin
                  p.im_prod[3*r+c] = 48'(IN_MAT[3*r+c]) * 48'(p.x[c]);
               end
            end
         end else if (i == S_ROW) begin
            for (int r = 0; r < 3; r++) begin
               rs  = 50'(p.im_prod[3*r]) + 50'(p.im_prod[3*r+1]) + 50'(p.im_prod[3*r+2]);
               s16 = 34'(rs >> 16);
               // flat region of the curve
               p.v[r] = (s16 > 34'h1000000) ? 25'h1000000 : s16[24:0];
            end
         end else if (i == S_P) begin
            for (int c = 0; c < NUM_CH; c++) begin
               p.p1[c] = 50'(p.v[c]) * 50'(26'(p.v[c]) + 26'd1611);
               p.p2[c] = 41'(p.v[c]) * 41'd64470;
            end
         end else if (i == S_AL) begin
            for (int c = 0; c < NUM_CH; c++) begin
               p.a[c]   = 47'(p.p1[c] >> 4) - 47'd24303;
               p.lin[c] = 25'(p.p2[c] >> 16) + 25'd28374;
            end
         end else if (i == S_BQ) begin
            for (int c = 0; c < NUM_CH; c++) begin
               p.bq[c] = 50'(p.v[c]) * 50'(p.lin[c]);
            end
         end else if (i == S_B) begin
            for (int c = 0; c < NUM_CH; c++) begin
               p.b[c]   = 47'(p.bq[c] >> 4) + 47'd63909382;
               p.neg[c] = p.a[c][46];
               mag      = p.a[c][46] ? (47'd0 - p.a[c]) : p.a[c];
               p.num[c] = 64'(mag) << 16;
               p.quo[c] = '0;
            end
         end else if (i >= S_DIV0 && i < S_F) begin
            // one quotient bit per stage, msb first
            for (int c = 0; c < NUM_CH; c++) begin
               trial = 65'(p.b[c]) << (DIV_STEPS - 1 - (i - S_DIV0));
               if (65'(p.num[c]) >= trial) begin
                  p.num[c] = p.num[c] - 64'(trial);
                  p.quo[c][DIV_STEPS-1-(i-S_DIV0)] = 1'b1;
               end
            end
         end else if (i == S_F) begin
            for (int c = 0; c < NUM_CH; c++) begin
               p.f[c] = p.neg[c] ? (19'd0 - 19'(p.quo[c])) : 19'(p.quo[c]);
            end
         end else if (i == S_OM) begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < NUM_CH; c++) begin
                  p.om_prod[3*r+c] = 37'(37'(OUT_MAT[3*r+c]) * 37'($signed(p.f[c])));
               end
            end
         end else if (i == S_OS) begin
            for (int r = 0; r < 3; r++) begin
               os = 39'($signed(p.om_prod[3*r])) + 39'($signed(p.om_prod[3*r+1])) +
                    39'($signed(p.om_prod[3*r+2]));
               mv = (os <= 39'sd0) ? 23'd0 : 23'(os >>> 16);
               val = aces ? X_W'(mv) : p.x[r];
               p.ge1[r] = (val >= X_W'(65536));
               p.xe[r]  = val[15:0];
               p.pw4[r] = '0;
               p.pw6[r] = '0;
               p.pw5[r] = '0;
            end
         end else if (i >= S_ROOT0 && i < S_PP) begin
            for (int c = 0; c < NUM_CH; c++) begin
               p.pw4[c] = root_step(p.pw4[c], 4, 14 - (i - S_ROOT0), p.xe[c]);
               if (i - S_ROOT0 < 10) begin
                  p.pw6[c] = root_step(p.pw6[c], 6, 9 - (i - S_ROOT0), p.xe[c]);
               end
               if (i - S_ROOT0 < 12) begin
                  p.pw5[c] = root_step(p.pw5[c], 5, 11 - (i - S_ROOT0), p.xe[c]);
               end
            end
         end else if (i == S_PP) begin
            for (int c = 0; c < NUM_CH; c++) begin
               p.pp[c] = rec ? 27'(p.pw4[c][1][14:0]) * 27'(p.pw5[c][1][11:0]) :
                               27'(p.pw4[c][1][14:0]) * 27'(p.pw6[c][1][9:0]);
            end
         end else if (i == S_YK) begin
            for (int c = 0; c < NUM_CH; c++) begin
               p.yk[c] = rec ? 52'd18443194 * 52'(p.pp[c]) : 52'd17699963 * 52'(p.pp[c]);
               p.sm[c] = rec ? 36'(p.xe[c]) * 36'd1152 : 36'(p.xe[c]) * 36'd846725;
            end
         end else if (i == S_Y) begin
            for (int c = 0; c < NUM_CH; c++) begin
               // linear toe below the knee
               small_in = rec ? (p.xe[c] < 16'd1187) : (p.xe[c] < 16'd206);
               if (small_in) begin
                  p.y[c] = rec ? 32'(p.sm[c]) : 32'(p.sm[c] >> 8);
               end else begin
                  p.y[c] = rec ? 32'(p.yk[c] >> 27) - 32'd1665978 :
                                 32'(p.yk[c] >> 25) - 32'd922747;
               end
            end
         end else if (i == S_OUT) begin
            for (int c = 0; c < NUM_CH; c++) begin
               lb = (40'(p.x[c]) * 40'd255) >> 16;
               yb = (40'(p.y[c]) * 40'd255) >> 24;
               case (p.mode) inside
                  MODE_LINEAR: begin
                     p.px[c] = (lb > 40'd255) ? 8'hff : lb[7:0];
                  end
                  MODE_SRGB, MODE_REC709, MODE_ACES_A, MODE_ACES_B, MODE_ACES_C: begin
                     if (p.ge1[c]) begin
                        p.px[c] = 8'hff;
                     end else if ($signed(p.y[c]) <= 32'sd0) begin
                        p.px[c] = 8'h00;
                     end else begin
                        p.px[c] = (yb > 40'd255) ? 8'hff : yb[7:0];
                     end
                  end
                  default: begin
                     p.px[c] = 8'h00;
                  end
               endcase
            end
         end
         pipe_in[i] = p;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_en[i]) begin
            valid_ff[i] <= valid_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // curve quotient never reaches 2.0
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_F] |-> !(pipe_ff[S_F].quo[0][17] || pipe_ff[S_F].quo[1][17] ||
                          pipe_ff[S_F].quo[2][17]))
      else $error("aces curve quotient out of range");

   // finished fourth root never overshoots its target
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[S_PP] |-> (pipe_ff[S_PP].pw4[0][4] <= {4'b0, pipe_ff[S_PP].xe[0], 44'b0}) &&
                         (pipe_ff[S_PP].pw4[1][4] <= {4'b0, pipe_ff[S_PP].xe[1], 44'b0}) &&
                         (pipe_ff[S_PP].pw4[2][4] <= {4'b0, pipe_ff[S_PP].xe[2], 44'b0}))
      else $error("root unit overshoot");

   // input only blocks when the first stage holds a word
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> valid_ff[0])
      else $error("input stalled with empty first stage");

   // an accepted word lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted word lost");

endmodule
